/* hdl/dda_line_rasterizer_styled_defines.svh */
// ----------------------------------------------------------------------------
// dda line rasterizer assertion macros
// concurrent check wrappers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_STYLED_DEFINES_SVH
`define DDA_LINE_RASTERIZER_STYLED_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DDA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dda same-cycle check failed");

// next-cycle implication
`define DDA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dda next-cycle check failed");

`else

`define DDA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define DDA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hdl/dda_pkg.sv */
// ----------------------------------------------------------------------------
// dda_pkg
// shared types, codes and dash patterns of the line rasterizer
// ----------------------------------------------------------------------------
package dda_pkg;

   localparam int YMAX_W = 10;
   localparam logic [YMAX_W-1:0] YMAX_RESET = 10'd479;

   localparam int PATTERN_LEN = 10;
   localparam int POS_W       = $clog2(PATTERN_LEN);

   localparam logic [PATTERN_LEN-1:0] PATTERN_SOLID     = 10'h3FF;
   localparam logic [PATTERN_LEN-1:0] PATTERN_ALTERNATE = 10'h155;
   localparam logic [PATTERN_LEN-1:0] PATTERN_GAP_SHORT = 10'h3DE;
   localparam logic [PATTERN_LEN-1:0] PATTERN_GAP_LONG  = 10'h0CF;

   localparam logic [2:0] STYLE_ALTERNATE = 3'd2;
   localparam logic [2:0] STYLE_GAP_SHORT = 3'd3;
   localparam logic [2:0] STYLE_GAP_LONG  = 3'd4;

   typedef enum logic {
      KIND_START   = 1'b0,
      KIND_ADVANCE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH,
      ST_PREP,
      ST_EMIT
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic advance;
      logic div_step;
      logic div_finish;
      logic prep;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic zero_len;
      logic line_active;
      logic slot_free;
   } sts_type;

   function automatic logic [PATTERN_LEN-1:0] style_pattern(input logic [2:0] style);
      logic [PATTERN_LEN-1:0] pat;
      unique case (style)
         STYLE_ALTERNATE: pat = PATTERN_ALTERNATE;
         STYLE_GAP_SHORT: pat = PATTERN_GAP_SHORT;
         STYLE_GAP_LONG:  pat = PATTERN_GAP_LONG;
         default:         pat = PATTERN_SOLID;
      endcase
      return pat;
   endfunction

endpackage

/* hdl/dda_if.sv */
// ----------------------------------------------------------------------------
// dda channel interfaces
// valid/ready channels for line items, pixels and the row limit register
// ----------------------------------------------------------------------------
interface dda_req_if #(
   parameter int COORD_WIDTH = 10
);
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [COORD_WIDTH-1:0] x_start;
   logic [COORD_WIDTH-1:0] y_start;
   logic [COORD_WIDTH-1:0] x_end;
   logic [COORD_WIDTH-1:0] y_end;
   logic [2:0]             style;

   modport source (output valid, kind, x_start, y_start, x_end, y_end, style, input ready);
   modport sink   (input valid, kind, x_start, y_start, x_end, y_end, style, output ready);
endinterface

interface dda_rsp_if #(
   parameter int COORD_WIDTH = 10
);
   logic                      valid;
   logic                      ready;
   logic [COORD_WIDTH-1:0]    pixel_x;
   logic signed [COORD_WIDTH:0] pixel_y;
   logic                      last;

   modport source (output valid, pixel_x, pixel_y, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

interface dda_csr_if;
   logic                        valid;
   logic                        ready;
   logic [dda_pkg::YMAX_W-1:0]  screen_y_max;

   modport source (output valid, screen_y_max, input ready);
   modport sink   (input valid, screen_y_max, output ready);
endinterface

/* hdl/dda_controller.sv */
// ----------------------------------------------------------------------------
// dda_controller
// sequencer for start, divide and advance phases of the rasterizer
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_styled_defines.svh"

module dda_controller #(
   parameter int DIV_STEPS = 26
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_kind,
   output logic              req_ready,
   input  dda_pkg::sts_type  sts,
   output dda_pkg::cmd_type  cmd
);

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   dda_pkg::ctl_state_type state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   accept;

   // outputs
   always_comb begin
      req_ready      = (state_ff == dda_pkg::ST_IDLE) && sts.slot_free;
      accept         = req_valid && req_ready;
      cmd            = '0;
      cmd.start      = accept && (req_kind == dda_pkg::KIND_START);
      cmd.advance    = accept && (req_kind == dda_pkg::KIND_ADVANCE) && sts.line_active;
      cmd.div_step   = (state_ff == dda_pkg::ST_DIVIDE);
      cmd.div_finish = (state_ff == dda_pkg::ST_FINISH);
      cmd.prep       = (state_ff == dda_pkg::ST_PREP);
      cmd.emit       = (state_ff == dda_pkg::ST_EMIT);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         dda_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (cmd.start && !sts.zero_len) begin
               state_in = dda_pkg::ST_DIVIDE;
            end else if (cmd.advance) begin
               state_in = dda_pkg::ST_PREP;
            end
         end
         dda_pkg::ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = dda_pkg::ST_FINISH;
            end
         end
         dda_pkg::ST_FINISH: state_in = dda_pkg::ST_IDLE;
         dda_pkg::ST_PREP:   state_in = dda_pkg::ST_EMIT;
         dda_pkg::ST_EMIT:   state_in = dda_pkg::ST_IDLE;
         default:            state_in = dda_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dda_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // a pixel is only produced into an empty or draining output slot
   `DDA_ASSERT_IMPL(a_emit_slot_free, clock, reset, state_ff == dda_pkg::ST_EMIT, sts.slot_free)
   // a real line start blocks new beats while dividing
   `DDA_ASSERT_NEXT(a_start_blocks, clock, reset, cmd.start && !sts.zero_len, !req_ready)

endmodule

/* hdl/dda_datapath.sv */
// ----------------------------------------------------------------------------
// dda_datapath
// endpoint setup, serial increment divider, accumulators, rounding, output slot
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_styled_defines.svh"

module dda_datapath #(
   parameter int COORD_WIDTH = 10,
   parameter int FRAC_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dda_pkg::cmd_type                cmd,
   output dda_pkg::sts_type                sts,
   input  logic [COORD_WIDTH-1:0]          x_start,
   input  logic [COORD_WIDTH-1:0]          y_start,
   input  logic [COORD_WIDTH-1:0]          x_end,
   input  logic [COORD_WIDTH-1:0]          y_end,
   input  logic [2:0]                      style,
   input  logic                            csr_valid,
   input  logic [dda_pkg::YMAX_W-1:0]      csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [COORD_WIDTH-1:0]          pixel_x,
   output logic signed [COORD_WIDTH:0]     pixel_y,
   output logic                            last
);

   localparam int C      = COORD_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int ACC_W  = C + F + 1;
   localparam int INC_W  = F + 2;
   localparam int DIV_W  = C + F;
   localparam int MAX_W  = (C > dda_pkg::YMAX_W) ? C : dda_pkg::YMAX_W;
   localparam int PY_W   = MAX_W + 1;
   localparam int VY_W   = MAX_W + F + 2;
   localparam int SX_W   = ACC_W + 1;
   localparam int SY_W   = VY_W + 1;
   localparam int PLEN   = dda_pkg::PATTERN_LEN;
   localparam int POS_W  = dda_pkg::POS_W;

   localparam logic signed [SX_W-1:0] X_HALF = SX_W'(64'd1 << (F - 1));
   localparam logic signed [SX_W-1:0] X_BIAS = SX_W'((64'd1 << F) + (64'd1 << (F - 1)) - 64'd1);
   localparam logic signed [SY_W-1:0] Y_HALF = SY_W'(64'd1 << (F - 1));
   localparam logic signed [SY_W-1:0] Y_BIAS = SY_W'((64'd1 << F) + (64'd1 << (F - 1)) - 64'd1);

   // control state
   logic [dda_pkg::YMAX_W-1:0] ymax_ff, ymax_in;
   logic [C-1:0]               steps_ff, steps_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [PLEN-1:0]            pattern_ff, pattern_in;
   logic                       active_ff, active_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload state, lane 0 is x, lane 1 is y
   logic signed [ACC_W-1:0]    acc_ff [2];
   logic signed [ACC_W-1:0]    acc_in [2];
   logic signed [INC_W-1:0]    inc_ff [2];
   logic signed [INC_W-1:0]    inc_in [2];
   logic [C-1:0]               rem_ff [2];
   logic [C-1:0]               rem_in [2];
   logic [DIV_W-1:0]           num_ff [2];
   logic [DIV_W-1:0]           num_in [2];
   logic                       neg_ff [2];
   logic                       neg_in [2];
   logic                       emit_ff, emit_in;
   logic                       step_last_ff, step_last_in;
   logic signed [VY_W-1:0]     vy_ff, vy_in;
   logic [C-1:0]               px_ff, px_in;
   logic signed [C:0]          py_ff, py_in;
   logic                       last_ff, last_in;

   // start decode
   logic signed [C:0]          dx_s, dy_s, adx_s, ady_s;
   logic [C-1:0]               steps_new;
   logic                       zero_len;
   logic signed [PY_W-1:0]     start_py;

   // divider step
   logic [C:0]                 trial [2];
   logic [C:0]                 diff [2];
   logic                       ge [2];
   logic [INC_W-1:0]           quo [2];

   // rounding
   logic signed [SX_W-1:0]     sx, rx;
   logic signed [SY_W-1:0]     sy, ry;

   always_comb begin
      dx_s      = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
      dy_s      = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
      adx_s     = dx_s[C] ? -dx_s : dx_s;
      ady_s     = dy_s[C] ? -dy_s : dy_s;
      steps_new = (adx_s[C-1:0] > ady_s[C-1:0]) ? adx_s[C-1:0] : ady_s[C-1:0];
      zero_len  = (steps_new == '0);
      start_py  = $signed(PY_W'(ymax_ff)) - $signed(PY_W'(y_start));
   end

   // restoring divide, one quotient bit per lane per cycle
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         trial[i] = {rem_ff[i], num_ff[i][DIV_W-1]};
         diff[i]  = trial[i] - {1'b0, steps_ff};
         ge[i]    = (trial[i] >= {1'b0, steps_ff});
         quo[i]   = {1'b0, num_ff[i][F:0]};
      end
   end

   // add one half, then truncate toward zero; ties round up
   always_comb begin
      sx = SX_W'(acc_ff[0]);
      rx = sx + ((sx < -X_HALF) ? X_BIAS : X_HALF);
      sy = SY_W'(vy_ff);
      ry = sy + ((sy < -Y_HALF) ? Y_BIAS : Y_HALF);
   end

   // control next values
   always_comb begin
      ymax_in    = csr_valid ? csr_data : ymax_ff;
      steps_in   = steps_ff;
      pos_in     = pos_ff;
      pattern_in = pattern_ff;
      active_in  = active_ff;
      if (cmd.start) begin
         steps_in   = steps_new;
         pos_in     = '0;
         pattern_in = dda_pkg::style_pattern(style);
         active_in  = !zero_len;
      end else if (cmd.advance) begin
         steps_in  = steps_ff - 1'b1;
         pos_in    = (pos_ff == POS_W'(PLEN - 1)) ? '0 : pos_ff + 1'b1;
         active_in = (steps_ff != C'(1));
      end

      if (cmd.start || (cmd.emit && emit_ff)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // payload next values
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         acc_in[i] = acc_ff[i];
         inc_in[i] = inc_ff[i];
         rem_in[i] = rem_ff[i];
         num_in[i] = num_ff[i];
         neg_in[i] = neg_ff[i];
      end
      emit_in      = emit_ff;
      step_last_in = step_last_ff;
      vy_in        = vy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;

      if (cmd.start) begin
         acc_in[0] = ACC_W'({1'b0, x_start, {F{1'b0}}});
         acc_in[1] = ACC_W'({1'b0, y_start, {F{1'b0}}});
         inc_in[0] = '0;
         inc_in[1] = '0;
         rem_in[0] = '0;
         rem_in[1] = '0;
         num_in[0] = {adx_s[C-1:0], {F{1'b0}}};
         num_in[1] = {ady_s[C-1:0], {F{1'b0}}};
         neg_in[0] = dx_s[C];
         neg_in[1] = dy_s[C];
         px_in     = x_start;
         py_in     = start_py[C:0];
         last_in   = zero_len;
      end else if (cmd.advance) begin
         for (int i = 0; i < 2; i++) begin
            acc_in[i] = acc_ff[i] + ACC_W'(inc_ff[i]);
         end
         emit_in      = pattern_ff[pos_ff];
         step_last_in = (steps_ff == C'(1));
      end

      if (cmd.div_step) begin
         for (int i = 0; i < 2; i++) begin
            rem_in[i] = ge[i] ? diff[i][C-1:0] : trial[i][C-1:0];
            num_in[i] = {num_ff[i][DIV_W-2:0], ge[i]};
         end
      end

      if (cmd.div_finish) begin
         for (int i = 0; i < 2; i++) begin
            inc_in[i] = neg_ff[i] ? $signed(-quo[i]) : $signed(quo[i]);
         end
      end

      if (cmd.prep) begin
         vy_in = $signed(VY_W'({ymax_ff, {F{1'b0}}})) - VY_W'(acc_ff[1]);
      end

      if (cmd.emit) begin
         px_in   = rx[F+C-1:F];
         py_in   = ry[F+C:F];
         last_in = step_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ymax_ff      <= dda_pkg::YMAX_RESET;
         steps_ff     <= '0;
         pos_ff       <= '0;
         pattern_ff   <= dda_pkg::PATTERN_SOLID;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ymax_ff      <= ymax_in;
         steps_ff     <= steps_in;
         pos_ff       <= pos_in;
         pattern_ff   <= pattern_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         acc_ff[i] <= acc_in[i];
         inc_ff[i] <= inc_in[i];
         rem_ff[i] <= rem_in[i];
         num_ff[i] <= num_in[i];
         neg_ff[i] <= neg_in[i];
      end
      emit_ff      <= emit_in;
      step_last_ff <= step_last_in;
      vy_ff        <= vy_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      last_ff      <= last_in;
   end

   assign sts.zero_len    = zero_len;
   assign sts.line_active = active_ff;
   assign sts.slot_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign pixel_x   = px_ff;
   assign pixel_y   = py_ff;
   assign last      = last_ff;

   // an active line always has steps left
   `DDA_ASSERT_IMPL(a_active_has_steps, clock, reset, active_ff, steps_ff != '0)
   // the final step closes the line
   `DDA_ASSERT_NEXT(a_last_step_ends, clock, reset, cmd.advance && (steps_ff == C'(1)), !active_ff)

endmodule

/* hdl/dda_line_rasterizer_styled.sv */
// ----------------------------------------------------------------------------
// dda_line_rasterizer_styled
// styled dda line rasterizer, at most one pixel per beat
// ----------------------------------------------------------------------------
// a start beat (kind 0) latches both endpoints and a dash style and the start
// pixel is loaded into the output register on accept; the block then runs a
// bit-serial restoring divider, one step per bit of the scaled delta, and
// signs the x and y increments in a finish step before the next beat is
// taken; a zero length line skips the divider. an advance beat (kind 1) steps
// the accumulators on accept, flips the screen row in the prep state and
// registers the rounded pixel in the emit state. an advance with no line
// active is dropped. the pixel sits in an output register, and a new beat is
// taken only while that register is empty or being drained in the same cycle.
// pixels falling on a gap of the dash pattern are not sent, so a line whose
// final step is masked ends without a pixel marked last. the row limit
// register is written through the csr channel, which is always ready.
`include "dda_line_rasterizer_styled_defines.svh"

module dda_line_rasterizer_styled #(
   parameter int COORD_WIDTH = 10,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   dda_req_if.sink     req_bus,
   dda_rsp_if.source   rsp_bus,
   dda_csr_if.sink     csr_bus
);

   // one divider step per bit of the scaled delta
   localparam int DIV_STEPS = COORD_WIDTH + FRAC_BITS;

   dda_pkg::cmd_type cmd;
   dda_pkg::sts_type sts;
   logic             req_ready;

   // register writes never stall
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;

   // sequencer: idle, divide, finish, prep, emit
   dda_controller #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic, line state and output slot
   dda_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .x_start   (req_bus.x_start),
      .y_start   (req_bus.y_start),
      .x_end     (req_bus.x_end),
      .y_end     (req_bus.y_end),
      .style     (req_bus.style),
      .csr_valid (csr_bus.valid),
      .csr_data  (csr_bus.screen_y_max),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .pixel_x   (rsp_bus.pixel_x),
      .pixel_y   (rsp_bus.pixel_y),
      .last      (rsp_bus.last)
   );

   // a beat accepted here leaves the pixel slot loaded on a start
   `DDA_ASSERT_NEXT(a_start_loads_pixel, clock, reset, cmd.start, rsp_bus.valid)

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the styled dda line rasterizer
// a software rasterizer follows every accepted beat and queues the pixel due,
// returned pixels are compared in order, the row limit changes between phases
// ----------------------------------------------------------------------------
module tb_top;

   localparam int COORD_W       = 10;
   localparam int FRAC_BITS     = 16;
   localparam int COORD_MAX     = (1 << COORD_W) - 1;
   // covers the divider and the step pipeline, with margin
   localparam int SETTLE_CYCLES = 40;
   // cycles with no beat moving on any channel before the run is abandoned
   localparam int STALL_LIMIT   = 2000;

   // styles with no pattern of their own draw solid
   localparam logic [2:0] STYLE_SOLID    = 3'd0;
   localparam logic [2:0] STYLE_PLAIN_LO = 3'd1;
   localparam logic [2:0] STYLE_PLAIN_HI = 3'd7;

   // dash masks, bit n governs the n-th step of the line
   localparam logic [9:0] DASH_SOLID     = 10'h3FF;
   localparam logic [9:0] DASH_ALTERNATE = 10'h155;
   localparam logic [9:0] DASH_GAP_SHORT = 10'h3DE;
   localparam logic [9:0] DASH_GAP_LONG  = 10'h0CF;

   typedef struct packed {
      logic [COORD_W-1:0] px;
      logic [COORD_W:0]   py;
      logic               last;
   } screen_pixel_type;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_COIN,
      SINK_SPARSE,
      SINK_BLOCKED
   } sink_mode_type;

   logic clock = 1'b0;
   logic reset;

   dda_req_if #(.COORD_WIDTH(COORD_W)) req_bus ();
   dda_rsp_if #(.COORD_WIDTH(COORD_W)) rsp_bus ();
   dda_csr_if                          csr_bus ();

   dda_line_rasterizer_styled #(
      .COORD_WIDTH (COORD_W),
      .FRAC_BITS   (FRAC_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // software rasterizer state, mirrors the block after every accepted beat
   // ------------------------------------------------------------------------
   logic [9:0]         row_limit;
   logic signed [26:0] x_acc;
   logic signed [26:0] y_acc;
   logic signed [17:0] x_inc;
   logic signed [17:0] y_inc;
   logic [10:0]        steps_left;
   logic [3:0]         dash_pos;
   logic [9:0]         dash_mask;
   bit                 line_on;

   screen_pixel_type   pending_pixels[$];
   int                 line_beats;     // beats that start or step a line
   int                 error_count;
   int                 burst_left;

   // increment per step, magnitude divided first, sign applied afterwards
   function automatic logic signed [17:0] slope_per_step(int d, int steps);
      int mag;
      int q;
      mag = (d < 0 ? -d : d) << FRAC_BITS;
      q   = mag / steps;
      return 18'(d < 0 ? -q : q);
   endfunction

   // add one half, then truncate toward zero
   function automatic int round_to_pixel(int v);
      int t;
      t = v + (1 << (FRAC_BITS - 1));
      if (t >= 0)
         return t >>> FRAC_BITS;
      return -((-t) >>> FRAC_BITS);
   endfunction

   function automatic logic [9:0] clamp_coord(int v);
      if (v < 0)
         return '0;
      if (v > COORD_MAX)
         return 10'(COORD_MAX);
      return 10'(v);
   endfunction

   // advance the mirror by one beat, returns 1 when a pixel is due
   function automatic bit rasterize_beat(input dda_pkg::kind_type kind,
                                         input logic [9:0] xs, ys, xe, ye,
                                         input logic [2:0] style,
                                         output screen_pixel_type pix);
      int dx;
      int dy;
      int adx;
      int ady;
      int steps;
      bit emit;
      pix = '0;
      if (kind == dda_pkg::KIND_START) begin
         dx    = int'(xe) - int'(xs);
         dy    = int'(ye) - int'(ys);
         adx   = dx < 0 ? -dx : dx;
         ady   = dy < 0 ? -dy : dy;
         steps = adx > ady ? adx : ady;
         case (style)
            dda_pkg::STYLE_ALTERNATE: dash_mask = DASH_ALTERNATE;
            dda_pkg::STYLE_GAP_SHORT: dash_mask = DASH_GAP_SHORT;
            dda_pkg::STYLE_GAP_LONG:  dash_mask = DASH_GAP_LONG;
            default:                  dash_mask = DASH_SOLID;
         endcase
         dash_pos   = '0;
         x_acc      = 27'(int'(xs) << FRAC_BITS);
         y_acc      = 27'(int'(ys) << FRAC_BITS);
         steps_left = 11'(steps);
         if (steps == 0) begin
            x_inc   = '0;
            y_inc   = '0;
            line_on = 1'b0;
         end else begin
            x_inc   = slope_per_step(dx, steps);
            y_inc   = slope_per_step(dy, steps);
            line_on = 1'b1;
         end
         line_beats++;
         // start pixel goes out whatever the dash pattern says
         pix.px   = xs;
         pix.py   = 11'(int'(row_limit) - int'(ys));
         pix.last = (steps == 0);
         return 1'b1;
      end
      if (!line_on)
         return 1'b0;
      line_beats++;
      emit       = dash_mask[dash_pos];
      x_acc      = x_acc + x_inc;
      y_acc      = y_acc + y_inc;
      dash_pos   = (dash_pos == 4'd9) ? 4'd0 : dash_pos + 4'd1;
      steps_left = steps_left - 11'd1;
      if (steps_left == 0)
         line_on = 1'b0;
      if (!emit)
         return 1'b0;
      pix.px   = 10'(round_to_pixel(int'(x_acc)));
      pix.py   = 11'(round_to_pixel((int'(row_limit) << FRAC_BITS) - int'(y_acc)));
      pix.last = (steps_left == 0);
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   // one beat; valid stays up across a burst and drops when the burst ends
   task automatic send_beat(input dda_pkg::kind_type kind,
                            input logic [9:0] xs, ys, xe, ye,
                            input logic [2:0] style);
      screen_pixel_type pix;
      int gap;
      if (burst_left == 0) begin
         // valid is already low here and stays low across the gap
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= kind;
      req_bus.x_start <= xs;
      req_bus.y_start <= ys;
      req_bus.x_end   <= xe;
      req_bus.y_end   <= ye;
      req_bus.style   <= style;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (rasterize_beat(kind, xs, ys, xe, ye, style, pix))
         pending_pixels.push_back(pix);
      burst_left--;
      if (burst_left == 0)
         req_bus.valid <= 1'b0;
   endtask

   task automatic start_line(input logic [9:0] xs, ys, xe, ye, input logic [2:0] style);
      send_beat(dda_pkg::KIND_START, xs, ys, xe, ye, style);
   endtask

   // step beats carry random endpoint bits, the block must ignore them
   task automatic advance_beat();
      send_beat(dda_pkg::KIND_ADVANCE, 10'($urandom), 10'($urandom), 10'($urandom),
                10'($urandom), 3'($urandom));
   endtask

   // stop sending, let every queued pixel arrive, then cover the divider
   task automatic wait_idle();
      if (burst_left != 0) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
      end
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // row limit only changes while the block is idle
   task automatic write_row_limit(input logic [9:0] value);
      wait_idle();
      csr_bus.valid        <= 1'b1;
      csr_bus.screen_y_max <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      row_limit = value;
   endtask

   // ------------------------------------------------------------------------
   // pixel sink, switches stall pattern each time the tick counter wraps
   // ------------------------------------------------------------------------
   sink_mode_type sink_mode;
   logic [5:0]    sink_tick;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_mode     <= SINK_OPEN;
         sink_tick     <= '0;
      end else begin
         sink_tick <= sink_tick + 6'd1;
         if (sink_tick == '0)
            sink_mode <= sink_mode_type'($urandom_range(0, 3));
         case (sink_mode)
            SINK_OPEN:    rsp_bus.ready <= 1'b1;
            SINK_COIN:    rsp_bus.ready <= 1'($urandom_range(0, 1));
            SINK_SPARSE:  rsp_bus.ready <= (sink_tick[1:0] == 2'd0);
            SINK_BLOCKED: rsp_bus.ready <= (sink_tick[5:4] == 2'd0);
            default:      rsp_bus.ready <= 1'b1;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // pixel checker, oldest expectation first
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : pixel_check
      screen_pixel_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d last=%0b",
                   rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.last);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_bus.pixel_x !== want.px) begin
               $error("pixel_x: expected %0d, got %0d", want.px, rsp_bus.pixel_x);
               error_count++;
            end
            if (rsp_bus.pixel_y !== want.py) begin
               $error("pixel_y: expected %0d, got %0d", $signed(want.py), rsp_bus.pixel_y);
               error_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_bus.last);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog, counts cycles in which no beat moves anywhere
   // ------------------------------------------------------------------------
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // corner lines at the reset row limit
   task automatic test_directed_lines();
      // step with no line running
      advance_beat();
      // zero length line, start pixel is also the last one
      start_line(10'd0, 10'd0, 10'd0, 10'd0, STYLE_SOLID);
      advance_beat();
      // full diagonal, dropped after three steps by the next start
      start_line(10'd0, 10'd0, 10'd1023, 10'd1023, dda_pkg::STYLE_GAP_SHORT);
      repeat (3) advance_beat();
      // both coordinates shrinking, rows come out negative
      start_line(10'd1023, 10'd1023, 10'd1021, 10'd1019, STYLE_PLAIN_HI);
      repeat (4) advance_beat();
      // alternate style, final step falls on a gap
      start_line(10'd5, 10'd7, 10'd6, 10'd5, dda_pkg::STYLE_ALTERNATE);
      repeat (2) advance_beat();
      start_line(10'd1023, 10'd1023, 10'd1023, 10'd1023, STYLE_PLAIN_LO);
      // long gaps, last step masked as well
      start_line(10'd100, 10'd200, 10'd106, 10'd197, dda_pkg::STYLE_GAP_LONG);
      repeat (6) advance_beat();
   endtask

   // row limit extremes, lines drawn to their end point
   task automatic test_row_limit();
      write_row_limit(10'd0);
      start_line(10'd0, 10'd100, 10'd60, 10'd0, STYLE_SOLID);
      repeat (100) advance_beat();
      write_row_limit(10'd1023);
      start_line(10'd3, 10'd0, 10'd40, 10'd9, dda_pkg::STYLE_GAP_SHORT);
      repeat (37) advance_beat();
      write_row_limit(10'($urandom));
   endtask

   // mostly complete short lines, some abandoned, some stray steps
   task automatic test_random_traffic();
      int target;
      int next_phase;
      int len;
      int steps;
      int n_steps;
      int dx;
      int dy;
      logic [9:0] xs, ys, xe, ye;
      target     = line_beats + 260;
      next_phase = line_beats + 90;
      while (line_beats < target) begin
         if (line_beats >= next_phase) begin
            next_phase = line_beats + 90;
            case ($urandom_range(0, 3))
               0:       write_row_limit(10'd0);
               1:       write_row_limit(10'd1023);
               default: write_row_limit(10'($urandom));
            endcase
         end
         if ($urandom_range(0, 9) == 0) begin
            advance_beat();
         end else begin
            xs = 10'($urandom);
            ys = 10'($urandom);
            if ($urandom_range(0, 4) == 0) begin
               // far endpoints, only a few steps before the next start
               xe      = 10'($urandom);
               ye      = 10'($urandom);
               n_steps = $urandom_range(0, 12);
            end else begin
               len = ($urandom_range(0, 7) == 0) ? 40 : 12;
               xe  = clamp_coord(int'(xs) + $urandom_range(0, 2 * len) - len);
               ye  = clamp_coord(int'(ys) + $urandom_range(0, 2 * len) - len);
               dx  = int'(xe) - int'(xs);
               dy  = int'(ye) - int'(ys);
               dx  = dx < 0 ? -dx : dx;
               dy  = dy < 0 ? -dy : dy;
               steps = dx > dy ? dx : dy;
               // a few extra steps land after the line has ended
               if ($urandom_range(0, 6) == 0)
                  n_steps = $urandom_range(0, steps);
               else
                  n_steps = steps + $urandom_range(0, 2);
            end
            start_line(xs, ys, xe, ye, 3'($urandom));
            repeat (n_steps) advance_beat();
         end
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.kind         = dda_pkg::KIND_START;
      req_bus.x_start      = '0;
      req_bus.y_start      = '0;
      req_bus.x_end        = '0;
      req_bus.y_end        = '0;
      req_bus.style        = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.screen_y_max = '0;
      row_limit            = dda_pkg::YMAX_RESET;
      x_acc                = '0;
      y_acc                = '0;
      x_inc                = '0;
      y_inc                = '0;
      steps_left           = '0;
      dash_pos             = '0;
      dash_mask            = DASH_SOLID;
      line_on              = 1'b0;
      line_beats           = 0;
      error_count          = 0;
      burst_left           = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_lines();
      test_row_limit();
      test_random_traffic();

      // drain what is left and give late extra pixels a chance to show up
      wait_idle();
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/dda_pkg.sv
hdl/dda_if.sv
hdl/dda_controller.sv
hdl/dda_datapath.sv
hdl/dda_line_rasterizer_styled.sv
tb/tb_top.sv
